@@ hdl/acb_pkg.sv @@
// ----------------------------------------------------------------------------
// acb_pkg
// Shared constants, types and helper functions for the ARX block stream
// cipher core: word widths, store regions, request kinds and the round
// primitives.
// ----------------------------------------------------------------------------
package acb_pkg;

   localparam int WORD_W      = 64;
   localparam int BLOCK_WORDS = 16;
   localparam int IDX_W       = $clog2(BLOCK_WORDS);
   localparam int ROT_AMOUNT  = 40;
   localparam int HALF_W      = WORD_W / 2;
   localparam int REGION_W    = 2;
   localparam int ADDR_W      = REGION_W + IDX_W;

   // request kinds
   localparam logic [1:0] KIND_KEY  = 2'd0;
   localparam logic [1:0] KIND_SEED = 2'd1;
   localparam logic [1:0] KIND_DATA = 2'd2;

   // memory regions: loaded copy, two ping-pong working banks, round key
   localparam logic [REGION_W-1:0] REG_LOADED = 2'd0;
   localparam logic [REGION_W-1:0] REG_BANK0  = 2'd1;
   localparam logic [REGION_W-1:0] REG_BANK1  = 2'd2;
   localparam logic [REGION_W-1:0] REG_RKEY   = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [IDX_W-1:0]  index;
      logic [WORD_W-1:0] value;
      logic              last;
   } acb_req_item_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
   } acb_rsp_item_type;

   typedef struct packed {
      logic idle;
      logic push;
   } acb_ctl_type;

   // left rotation by the fixed amount
   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] w);
      rotl = (w << ROT_AMOUNT) | (w >> (WORD_W - ROT_AMOUNT));
   endfunction

   // region of a working bank
   function automatic logic [REGION_W-1:0] bank_region(input logic b);
      bank_region = b ? REG_BANK1 : REG_BANK0;
   endfunction

   // source position of permuted word n
   function automatic logic [IDX_W-1:0] inv_perm(input logic [IDX_W-1:0] n);
      logic [IDX_W-1:0] r;
      unique case (n)
         4'd0:  r = 4'd11;
         4'd1:  r = 4'd5;
         4'd2:  r = 4'd4;
         4'd3:  r = 4'd15;
         4'd4:  r = 4'd12;
         4'd5:  r = 4'd6;
         4'd6:  r = 4'd9;
         4'd7:  r = 4'd0;
         4'd8:  r = 4'd13;
         4'd9:  r = 4'd3;
         4'd10: r = 4'd14;
         4'd11: r = 4'd8;
         4'd12: r = 4'd1;
         4'd13: r = 4'd10;
         4'd14: r = 4'd2;
         4'd15: r = 4'd7;
         default: r = 4'd0;
      endcase
      inv_perm = r;
   endfunction

endpackage

@@ hdl/acb_ram.sv @@
// ----------------------------------------------------------------------------
// acb_ram
// Synchronous RAM, one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module acb_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_a_addr,
   output logic [DATA_W-1:0] rd_a_data,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [DATA_W-1:0] rd_b_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   // write, and registered read on both ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

@@ hdl/acb_core.sv @@
// ----------------------------------------------------------------------------
// acb_core
// Sequencer and datapath. Key and seed stores live in two RAMs; block
// generation reads, mixes and writes back one word per step.
// ----------------------------------------------------------------------------
module acb_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  acb_pkg::acb_req_item_type req,
   input  logic                      slot_free,
   output acb_pkg::acb_ctl_type      ctl,
   output acb_pkg::acb_rsp_item_type rsp
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_FOLD = 4'd1;
   localparam logic [3:0] ST_PRE  = 4'd2;
   localparam logic [3:0] ST_MIX  = 4'd3;
   localparam logic [3:0] ST_FIX  = 4'd4;
   localparam logic [3:0] ST_PRF  = 4'd5;
   localparam logic [3:0] ST_DRD  = 4'd6;
   localparam logic [3:0] ST_DXOR = 4'd7;
   localparam logic [3:0] ST_DLV  = 4'd8;

   localparam int W  = acb_pkg::WORD_W;
   localparam int IW = acb_pkg::IDX_W;
   localparam int AW = acb_pkg::ADDR_W;
   localparam int BW = acb_pkg::BLOCK_WORDS;

   logic [3:0]    state_ff, state_in;
   logic [1:0]    sub_ff, sub_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          sel_ff, sel_in;
   logic          key_bank_ff, key_bank_in;
   logic          seed_bank_ff, seed_bank_in;
   logic [BW-1:0] key_useld_ff, key_useld_in;
   logic [BW-1:0] seed_useld_ff, seed_useld_in;
   logic [BW-1:0] key_ldv_ff, key_ldv_in;
   logic [BW-1:0] seed_ldv_ff, seed_ldv_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [IW-1:0] rdidx_ff;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  first_ff, first_in;
   logic [W-1:0]  cur_ff, cur_in;
   logic [W-1:0]  s_ff, s_in;
   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  l_ff, l_in;
   logic [W-1:0]  val_ff, val_in;
   logic          last_ff, last_in;
   logic [W-1:0]  res_ff, res_in;

   logic [IW-1:0] rd_idx;
   logic [AW-1:0] key_ra, key_rb, seed_ra, seed_rb;
   logic [W-1:0]  key_rda, key_rdb, seed_rda, seed_rdb;
   logic          key_we, seed_we;
   logic [AW-1:0] key_wa, seed_wa;
   logic [W-1:0]  key_wd, seed_wd;
   logic [W-1:0]  key_work, seed_work, work_rd, src;
   logic [W-1:0]  new_word;
   logic [AW-1:0] new_addr;
   logic [W-1:0]  k1, v0n, r_sel, r2, l2, b;

   acb_ram #(.ADDR_W(AW), .DATA_W(W)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
      .rd_a_addr(key_ra), .rd_a_data(key_rda),
      .rd_b_addr(key_rb), .rd_b_data(key_rdb)
   );

   acb_ram #(.ADDR_W(AW), .DATA_W(W)) u_seed_ram (
      .clock(clock), .wr_en(seed_we), .wr_addr(seed_wa), .wr_data(seed_wd),
      .rd_a_addr(seed_ra), .rd_a_data(seed_rda),
      .rd_b_addr(seed_rb), .rd_b_data(seed_rdb)
   );

   // read addresses
   always_comb begin
      unique case (state_ff)
         ST_MIX:  rd_idx = acb_pkg::inv_perm(cnt_ff + IW'(1));
         ST_DRD:  rd_idx = pos_ff;
         default: rd_idx = cnt_ff;
      endcase
      key_ra  = sel_ff ? {acb_pkg::REG_RKEY, rd_idx}
                       : {acb_pkg::bank_region(key_bank_ff), rd_idx};
      key_rb  = {acb_pkg::REG_LOADED, rd_idx};
      seed_ra = {acb_pkg::bank_region(seed_bank_ff), rd_idx};
      seed_rb = {acb_pkg::REG_LOADED, rd_idx};
   end

   // working word: loaded copy where flagged, zero where never loaded
   always_comb begin
      key_work  = key_useld_ff[rdidx_ff] ? (key_ldv_ff[rdidx_ff] ? key_rdb : '0)
                                         : key_rda;
      seed_work = seed_useld_ff[rdidx_ff] ? (seed_ldv_ff[rdidx_ff] ? seed_rdb : '0)
                                          : seed_rda;
      work_rd   = sel_ff ? seed_work : key_work;
      src       = sel_ff ? (seed_work ^ key_rda) : key_work;
      new_addr  = sel_ff ? {acb_pkg::bank_region(~seed_bank_ff), cnt_ff}
                         : {acb_pkg::bank_region(~key_bank_ff), cnt_ff};
   end

   // arithmetic of each step
   always_comb begin
      k1    = acc_ff ^ first_ff;
      v0n   = first_ff + k1;
      r_sel = (cnt_ff == IW'(BW - 1)) ? first_ff : src;
      r2    = acb_pkg::rotl(s_ff);
      l2    = l_ff ^ acb_pkg::rotl(r_ff);
      b     = acb_pkg::rotl(work_rd + acc_ff + W'(cnt_ff));
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sub_in        = sub_ff;
      cnt_in        = cnt_ff;
      sel_in        = sel_ff;
      key_bank_in   = key_bank_ff;
      seed_bank_in  = seed_bank_ff;
      key_useld_in  = key_useld_ff;
      seed_useld_in = seed_useld_ff;
      key_ldv_in    = key_ldv_ff;
      seed_ldv_in   = seed_ldv_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      first_in      = first_ff;
      cur_in        = cur_ff;
      s_in          = s_ff;
      r_in          = r_ff;
      l_in          = l_ff;
      val_in        = val_ff;
      last_in       = last_ff;
      res_in        = res_ff;
      key_we        = 1'b0;
      key_wa        = '0;
      key_wd        = '0;
      seed_we       = 1'b0;
      seed_wa       = '0;
      seed_wd       = '0;
      new_word      = '0;
      ctl.push      = 1'b0;
      ctl.idle      = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req.kind)
                  acb_pkg::KIND_KEY: begin
                     key_we = 1'b1;
                     key_wa = {acb_pkg::REG_LOADED, req.index};
                     key_wd = req.value;
                     key_ldv_in[req.index]   = 1'b1;
                     key_useld_in[req.index] = 1'b1;
                     pos_in = '0;
                  end
                  acb_pkg::KIND_SEED: begin
                     seed_we = 1'b1;
                     seed_wa = {acb_pkg::REG_LOADED, req.index};
                     seed_wd = req.value;
                     seed_ldv_in[req.index]   = 1'b1;
                     seed_useld_in[req.index] = 1'b1;
                     pos_in = '0;
                  end
                  acb_pkg::KIND_DATA: begin
                     val_in  = req.value;
                     last_in = req.last;
                     cnt_in  = '0;
                     sub_in  = '0;
                     if (pos_ff == '0) begin
                        sel_in   = 1'b0;
                        acc_in   = '0;
                        state_in = ST_FOLD;
                     end else begin
                        sel_in   = 1'b1;
                        state_in = ST_DRD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // fold all words, catch the word that lands at position 0
         ST_FOLD: begin
            if (sub_ff == 2'd0) begin
               sub_in = 2'd1;
            end else begin
               acc_in = acc_ff ^ src;
               if (rdidx_ff == acb_pkg::inv_perm('0)) begin
                  first_in = src;
               end
               sub_in = 2'd0;
               cnt_in = cnt_ff + IW'(1);
               if (cnt_ff == IW'(BW - 1)) begin
                  state_in = ST_PRE;
               end
            end
         end
         ST_PRE: begin
            acc_in   = k1 ^ v0n;
            cur_in   = v0n;
            cnt_in   = '0;
            sub_in   = 2'd0;
            state_in = ST_MIX;
         end
         // one add-rotate-xor step per word, after the word is read
         ST_MIX: begin
            unique case (sub_ff)
               2'd0: sub_in = 2'd1;
               2'd1: begin
                  acc_in = acc_ff ^ r_sel;
                  s_in   = r_sel + (acc_ff ^ r_sel) + W'(cnt_ff);
                  sub_in = 2'd2;
               end
               2'd2: begin
                  r_in   = r2;
                  acc_in = acc_ff ^ r2 ^ cur_ff;
                  l_in   = cur_ff + (r2 >> acb_pkg::HALF_W);
                  sub_in = 2'd3;
               end
               2'd3: begin
                  acc_in   = acc_ff ^ l2;
                  new_word = l2;
                  cur_in   = r_ff;
                  if (cnt_ff == '0) begin
                     first_in = l2;
                  end
                  if (sel_ff) begin
                     seed_we = 1'b1;
                     seed_wa = new_addr;
                     seed_wd = new_word;
                  end else begin
                     key_we = 1'b1;
                     key_wa = new_addr;
                     key_wd = new_word;
                  end
                  cnt_in = cnt_ff + IW'(1);
                  sub_in = 2'd0;
                  if (cnt_ff == IW'(BW - 1)) begin
                     state_in = ST_FIX;
                  end
               end
               default: sub_in = 2'd0;
            endcase
         end
         // last rotation lands in word 0, then swap banks
         ST_FIX: begin
            if (sel_ff) begin
               seed_we       = 1'b1;
               seed_wa       = {acb_pkg::bank_region(~seed_bank_ff), IW'(0)};
               seed_wd       = cur_ff;
               seed_bank_in  = ~seed_bank_ff;
               seed_useld_in = '0;
            end else begin
               key_we       = 1'b1;
               key_wa       = {acb_pkg::bank_region(~key_bank_ff), IW'(0)};
               key_wd       = cur_ff;
               key_bank_in  = ~key_bank_ff;
               key_useld_in = '0;
            end
            cnt_in   = '0;
            sub_in   = 2'd0;
            state_in = ST_PRF;
         end
         // derive round key, or keystream word from seed
         ST_PRF: begin
            if (sub_ff == 2'd0) begin
               sub_in = 2'd1;
            end else begin
               acc_in = acc_ff ^ b;
               if (sel_ff) begin
                  seed_we = 1'b1;
                  seed_wa = {acb_pkg::bank_region(seed_bank_ff), cnt_ff};
                  seed_wd = b ^ key_rda;
               end else begin
                  key_we = 1'b1;
                  key_wa = {acb_pkg::REG_RKEY, cnt_ff};
                  key_wd = b;
               end
               cnt_in = cnt_ff + IW'(1);
               sub_in = 2'd0;
               if (cnt_ff == IW'(BW - 1)) begin
                  if (sel_ff) begin
                     state_in = ST_DRD;
                  end else begin
                     sel_in   = 1'b1;
                     acc_in   = '0;
                     state_in = ST_FOLD;
                  end
               end
            end
         end
         ST_DRD: state_in = ST_DXOR;
         ST_DXOR: begin
            res_in   = val_ff ^ seed_work;
            state_in = ST_DLV;
         end
         // hold result until the output register frees
         ST_DLV: begin
            if (slot_free) begin
               ctl.push = 1'b1;
               pos_in   = pos_ff + IW'(1);
               if (last_ff) begin
                  key_useld_in  = '1;
                  seed_useld_in = '1;
                  pos_in        = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.word = res_ff;
   assign rsp.last = last_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sub_ff        <= '0;
         cnt_ff        <= '0;
         sel_ff        <= 1'b0;
         key_bank_ff   <= 1'b0;
         seed_bank_ff  <= 1'b0;
         key_useld_ff  <= '1;
         seed_useld_ff <= '1;
         key_ldv_ff    <= '0;
         seed_ldv_ff   <= '0;
         pos_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         sub_ff        <= sub_in;
         cnt_ff        <= cnt_in;
         sel_ff        <= sel_in;
         key_bank_ff   <= key_bank_in;
         seed_bank_ff  <= seed_bank_in;
         key_useld_ff  <= key_useld_in;
         seed_useld_ff <= seed_useld_in;
         key_ldv_ff    <= key_ldv_in;
         seed_ldv_ff   <= seed_ldv_in;
         pos_ff        <= pos_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rdidx_ff <= rd_idx;
      acc_ff   <= acc_in;
      first_ff <= first_in;
      cur_ff   <= cur_in;
      s_ff     <= s_in;
      r_ff     <= r_in;
      l_ff     <= l_in;
      val_ff   <= val_in;
      last_ff  <= last_in;
      res_ff   <= res_in;
   end

endmodule

@@ hdl/arx_block_stream_cipher_core.sv @@
// ----------------------------------------------------------------------------
// arx_block_stream_cipher_core
// ARX stream cipher: loads a 16-word key and seed, XORs data words with a
// keystream block generated every 16 words, and anew after a last word.
//
//  channel | ports                                        | direction
//  req     | req_valid req_ready req_type req_word_index  | in
//          | req_word_value req_last_word                 |
//  rsp     | rsp_valid rsp_ready rsp_out_word rsp_out_last| out
//
// A key or seed word is written while the core stays idle. A data word
// reads the keystream RAM, is XORed and delivered; at block position 0 it
// first generates a block: per store, key and then seed, fold, pre-mix,
// mix, fix and derive.
// Reset clears control only; loaded stores read as zero until written.
// A result waits in the output register while loads are still taken; a
// data word stalls in delivery until that register frees.
// ----------------------------------------------------------------------------
module arx_block_stream_cipher_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_type,
   input  logic [acb_pkg::IDX_W-1:0]   req_word_index,
   input  logic [acb_pkg::WORD_W-1:0]  req_word_value,
   input  logic                        req_last_word,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [acb_pkg::WORD_W-1:0]  rsp_out_word,
   output logic                        rsp_out_last
);

   acb_pkg::acb_req_item_type req;
   acb_pkg::acb_rsp_item_type rsp;
   acb_pkg::acb_ctl_type      ctl;
   logic                      start;
   logic                      slot_free;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [acb_pkg::WORD_W-1:0] rsp_word_ff;
   logic                      rsp_last_ff;

   assign req.kind  = req_type;
   assign req.index = req_word_index;
   assign req.value = req_word_value;
   assign req.last  = req_last_word;

   assign req_ready = ctl.idle;
   assign start     = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   acb_core u_core (
      .clock(clock), .reset(reset), .start(start), .req(req),
      .slot_free(slot_free), .ctl(ctl), .rsp(rsp)
   );

   // output word register
   always_comb begin
      if (ctl.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         rsp_word_ff <= rsp.word;
         rsp_last_ff <= rsp.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_word = rsp_word_ff;
   assign rsp_out_last = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> (!rsp_valid_ff || rsp_ready))
      else $error("result pushed over a waiting word");
   a_push_shown: assert property (@(posedge clock) disable iff (reset)
      ctl.push |=> rsp_valid_ff)
      else $error("pushed result not presented");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && (req_type == acb_pkg::KIND_KEY || req_type == acb_pkg::KIND_SEED))
      |=> ctl.idle)
      else $error("load word left the core busy");
`endif

endmodule
